/* rtl/lks_pkg.sv */
// Shared types and constants for the link keepalive supervisor.
// No dependencies; imported by every rtl module.
`default_nettype none
package lks_pkg;

	localparam int TS_W   = 32;
	localparam int CFG_W  = 16;
	localparam int SEQ_W  = 16;
	localparam int IDX_W  = 2;
	localparam int IN_W   = 56;
	localparam int OUT_W  = 24;

	// action codes
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_BYTE  = 2'd1;
	localparam logic [1:0] ACT_FRAME = 2'd2;

	// received frame kinds
	localparam logic [1:0] KIND_PING = 2'd0;

	// frame kinds to send
	localparam logic SEND_PING = 1'b0;
	localparam logic SEND_PONG = 1'b1;

	// register indexes
	localparam logic [IDX_W-1:0] REG_PING_PERIOD  = 2'd0;
	localparam logic [IDX_W-1:0] REG_LINK_TIMEOUT = 2'd1;
	localparam logic [IDX_W-1:0] REG_TX_PULSE     = 2'd2;
	localparam logic [IDX_W-1:0] REG_RX_PULSE     = 2'd3;

	localparam logic [CFG_W-1:0] PING_PERIOD_RST  = 16'd500;
	localparam logic [CFG_W-1:0] LINK_TIMEOUT_RST = 16'd1500;
	localparam logic [CFG_W-1:0] TX_PULSE_RST     = 16'd60;
	localparam logic [CFG_W-1:0] RX_PULSE_RST     = 16'd250;

	// heartbeat half period is 500 ms = 4 * 125; quotient of (ts >> 2) by 125
	// is (x * ceil(2^37 / 125)) >> 37, exact for 30-bit x
	localparam int BEAT_X_W     = TS_W - 2;
	localparam int BEAT_M_W     = 31;
	localparam int BEAT_SHIFT   = 37;
	localparam logic [BEAT_M_W-1:0] BEAT_RECIP = 31'd1099511628;

	typedef struct packed {
		logic             send_request;
		logic             send_kind;
		logic [SEQ_W-1:0] send_sequence;
		logic             alive;
		logic             lost_pulse;
		logic             activity;
	} lks_result_t;

endpackage
`default_nettype wire

/* rtl/link_keepalive_supervisor.sv */
// Link keepalive supervisor, top level: input register, state logic, result register.
// Throughput one beat per cycle while m_tready is high.
// Stalls propagate back through a stage only when that stage holds a beat.
// arst_n clears valids, supervisor state and restores register defaults
// (period 500, timeout 1500, tx hold 60, rx hold 250). Depends on lks_pkg,
// lks_state, lks_beat.
`default_nettype none
module link_keepalive_supervisor
	import lks_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// action[1:0], timestamp_ms[33:2], frame_kind[35:34], frame_sequence[51:36]
	input  wire logic [IN_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// send_request[0], send_kind[1], send_sequence[17:2], alive[18],
	// lost_pulse[19], link_lamp[20], activity_lamp[21]
	output logic [OUT_W-1:0]      m_tdata
);

	logic             v_s1, v_s2, en1, en2, step;
	logic [1:0]       action_s1, kind_s1;
	logic [TS_W-1:0]  now_s1;
	logic [SEQ_W-1:0] fseq_s1;
	lks_result_t      res, res_s2;
	logic             phase_odd;

	assign en2      = !v_s2 || m_tready;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;
	assign step     = v_s1 && en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			action_s1 <= s_tdata[1:0];
			now_s1    <= s_tdata[33:2];
			kind_s1   <= s_tdata[35:34];
			fseq_s1   <= s_tdata[51:36];
		end
		if (step) begin
			res_s2 <= res;
		end
	end

	lks_state u_state (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.step          (step),
		.action        (action_s1),
		.now           (now_s1),
		.frame_kind    (kind_s1),
		.frame_sequence(fseq_s1),
		.result        (res)
	);

	lks_beat u_beat (
		.clk      (clk),
		.en       (step),
		.now      (now_s1),
		.phase_odd(phase_odd)
	);

	assign m_tvalid = v_s2;
	assign m_tdata  = {2'b00, res_s2.activity, res_s2.alive || !phase_odd,
		res_s2.lost_pulse, res_s2.alive, res_s2.send_sequence,
		res_s2.send_kind, res_s2.send_request};

endmodule
`default_nettype wire

/* rtl/lks_state.sv */
// Config registers, supervisor state and per-beat result logic.
// Depends on lks_pkg.
`default_nettype none
module lks_state
	import lks_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             step,
	input  wire logic [1:0]       action,
	input  wire logic [TS_W-1:0]  now,
	input  wire logic [1:0]       frame_kind,
	input  wire logic [SEQ_W-1:0] frame_sequence,
	output lks_result_t           result
);

	logic [CFG_W-1:0] ping_period_q, link_timeout_q, tx_pulse_q, rx_pulse_q;
	logic [TS_W-1:0]  last_ping_q, last_rx_q, tx_until_q, rx_until_q;
	logic [SEQ_W-1:0] next_seq_q;
	logic             link_up_q;

	logic [TS_W-1:0]  last_ping_d, last_rx_d, tx_until_d, rx_until_d;
	logic [SEQ_W-1:0] next_seq_d;
	logic             link_up_d;

	logic [TS_W-1:0]  ping_age, rx_age, tx_left, rx_left;
	logic             is_tick, is_byte, is_frame, ping_due, timed_out;
	logic             tx_pend, rx_pend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ping_period_q  <= PING_PERIOD_RST;
			link_timeout_q <= LINK_TIMEOUT_RST;
			tx_pulse_q     <= TX_PULSE_RST;
			rx_pulse_q     <= RX_PULSE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PING_PERIOD:  ping_period_q  <= cfg_data;
				REG_LINK_TIMEOUT: link_timeout_q <= cfg_data;
				REG_TX_PULSE:     tx_pulse_q     <= cfg_data;
				REG_RX_PULSE:     rx_pulse_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign is_tick  = (action == ACT_TICK);
	assign is_byte  = (action == ACT_BYTE);
	assign is_frame = (action == ACT_FRAME);

	assign ping_age  = now - last_ping_q;
	assign rx_age    = now - last_rx_q;
	assign ping_due  = is_tick && (ping_age >= {{(TS_W-CFG_W){1'b0}}, ping_period_q});
	assign timed_out = is_tick && link_up_q
		&& (rx_age >= {{(TS_W-CFG_W){1'b0}}, link_timeout_q});

	// a pulse restarted by this beat ends now + hold, so only the hold matters
	assign tx_left = tx_until_q - now;
	assign rx_left = rx_until_q - now;
	assign tx_pend = ping_due ? (tx_pulse_q != '0) : (tx_left != '0 && !tx_left[TS_W-1]);
	assign rx_pend = is_byte ? (rx_pulse_q != '0) : (rx_left != '0 && !rx_left[TS_W-1]);

	always_comb begin
		last_ping_d = last_ping_q;
		last_rx_d   = last_rx_q;
		tx_until_d  = tx_until_q;
		rx_until_d  = rx_until_q;
		next_seq_d  = next_seq_q;
		link_up_d   = link_up_q;
		result      = '0;
		if (ping_due) begin
			result.send_request  = 1'b1;
			result.send_kind     = SEND_PING;
			result.send_sequence = next_seq_q;
			next_seq_d  = next_seq_q + 1'b1;
			tx_until_d  = now + {{(TS_W-CFG_W){1'b0}}, tx_pulse_q};
			last_ping_d = now;
		end
		if (timed_out) begin
			link_up_d         = 1'b0;
			result.lost_pulse = 1'b1;
		end
		if (is_byte) begin
			rx_until_d = now + {{(TS_W-CFG_W){1'b0}}, rx_pulse_q};
		end
		if (is_frame) begin
			last_rx_d = now;
			link_up_d = 1'b1;
			if (frame_kind == KIND_PING) begin
				result.send_request  = 1'b1;
				result.send_kind     = SEND_PONG;
				result.send_sequence = frame_sequence;
			end
		end
		result.alive    = link_up_d;
		result.activity = tx_pend || rx_pend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ping_q <= '0;
			last_rx_q   <= '0;
			tx_until_q  <= '0;
			rx_until_q  <= '0;
			next_seq_q  <= '0;
			link_up_q   <= 1'b0;
		end else if (step) begin
			last_ping_q <= last_ping_d;
			last_rx_q   <= last_rx_d;
			tx_until_q  <= tx_until_d;
			rx_until_q  <= rx_until_d;
			next_seq_q  <= next_seq_d;
			link_up_q   <= link_up_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/lks_beat.sv */
// Heartbeat phase: parity of timestamp / 500 via reciprocal multiply,
// registered into the output stage. Depends on lks_pkg.
`default_nettype none
module lks_beat
	import lks_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [TS_W-1:0] now,
	output logic                 phase_odd
);

	logic [BEAT_X_W+BEAT_M_W-1:0] prod;
	logic                         odd_s2;

	assign prod = {{BEAT_M_W{1'b0}}, now[TS_W-1:2]} * {{BEAT_X_W{1'b0}}, BEAT_RECIP};

	always_ff @(posedge clk) begin
		if (en) begin
			odd_s2 <= prod[BEAT_SHIFT];
		end
	end

	assign phase_odd = odd_s2;

endmodule
`default_nettype wire

/* rtl/lks_checker.sv */
// Port-level checks for link_keepalive_supervisor, bound to the top level.
// Depends on lks_pkg and the top level's ports.
`default_nettype none
module lks_checker
	import lks_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata
);

	// no request means kind and sequence are zero
	a_idle_send: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[17:1] == '0)
		else $error("send fields set without request");

	// a timeout leaves the link down
	a_lost_down: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[19] |-> !m_tdata[18])
		else $error("lost pulse with link alive");

	// alive link shows a solid lamp
	a_alive_lamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[18] |-> m_tdata[20])
		else $error("link lamp dark while alive");

	// stalled output beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed under stall");

endmodule

bind link_keepalive_supervisor lks_checker u_lks_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire

/* tb/keepalive_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the link keepalive supervisor: tracks register writes, predicts
// one status beat per accepted input beat and compares output beats in order.
// Depends on lks_pkg for register indexes, action codes and widths.
module keepalive_checker
	import lks_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             s_tvalid,
	input  wire logic             s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,
	input  wire logic             m_tvalid,
	input  wire logic             m_tready,
	input  wire logic [OUT_W-1:0] m_tdata,
	output int                    mismatches,
	output int                    outstanding
);

	localparam logic [TS_W-1:0] BEAT_HALF_MS = 32'd500;

	typedef struct packed {
		logic             send_request;
		logic             send_kind;
		logic [SEQ_W-1:0] send_sequence;
		logic             alive;
		logic             lost_pulse;
		logic             link_lamp;
		logic             activity_lamp;
	} link_status_t;

	logic [CFG_W-1:0] period_cfg;
	logic [CFG_W-1:0] timeout_cfg;
	logic [CFG_W-1:0] tx_hold_cfg;
	logic [CFG_W-1:0] rx_hold_cfg;

	logic [TS_W-1:0]  ping_stamp;
	logic [TS_W-1:0]  rx_good_stamp;
	logic [TS_W-1:0]  tx_hold_end;
	logic [TS_W-1:0]  rx_hold_end;
	logic [SEQ_W-1:0] ping_seq;
	logic             link_ok;

	link_status_t predicted_q[$];
	int           errors = 0;

	assign mismatches = errors;

	// pulse still running: end lies strictly ahead of now, modulo 2^32
	function automatic logic hold_running(input logic [TS_W-1:0] end_ts, input logic [TS_W-1:0] now);
		logic [TS_W-1:0] d;
		d = end_ts - now;
		return (d != '0) && !d[TS_W-1];
	endfunction

	function automatic link_status_t supervise_item(input logic [1:0] action,
			input logic [TS_W-1:0] now, input logic [1:0] kind, input logic [SEQ_W-1:0] fseq);
		link_status_t st;
		logic [TS_W-1:0] half;
		st = '0;
		case (action)
			ACT_TICK: begin
				if ((now - ping_stamp) >= {16'd0, period_cfg}) begin
					st.send_request  = 1'b1;
					st.send_kind     = SEND_PING;
					st.send_sequence = ping_seq;
					ping_seq         = ping_seq + 1'b1;
					tx_hold_end      = now + {16'd0, tx_hold_cfg};
					ping_stamp       = now;
				end
				if (link_ok && (now - rx_good_stamp) >= {16'd0, timeout_cfg}) begin
					link_ok       = 1'b0;
					st.lost_pulse = 1'b1;
				end
			end
			ACT_BYTE: rx_hold_end = now + {16'd0, rx_hold_cfg};
			ACT_FRAME: begin
				rx_good_stamp = now;
				link_ok       = 1'b1;
				if (kind == KIND_PING) begin
					st.send_request  = 1'b1;
					st.send_kind     = SEND_PONG;
					st.send_sequence = fseq;
				end
			end
			default: ;
		endcase
		half = now / BEAT_HALF_MS;
		st.alive         = link_ok;
		st.link_lamp     = link_ok || !half[0];
		st.activity_lamp = hold_running(rx_hold_end, now) || hold_running(tx_hold_end, now);
		return st;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		link_status_t want;
		if (!arst_n) begin
			period_cfg    = PING_PERIOD_RST;
			timeout_cfg   = LINK_TIMEOUT_RST;
			tx_hold_cfg   = TX_PULSE_RST;
			rx_hold_cfg   = RX_PULSE_RST;
			ping_stamp    = '0;
			rx_good_stamp = '0;
			tx_hold_end   = '0;
			rx_hold_end   = '0;
			ping_seq      = '0;
			link_ok       = 1'b0;
			predicted_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PING_PERIOD:  period_cfg  = cfg_data;
					REG_LINK_TIMEOUT: timeout_cfg = cfg_data;
					REG_TX_PULSE:     tx_hold_cfg = cfg_data;
					REG_RX_PULSE:     rx_hold_cfg = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predicted_q.push_back(supervise_item(s_tdata[1:0], s_tdata[33:2],
					s_tdata[35:34], s_tdata[51:36]));
			if (m_tvalid && m_tready) begin
				if (predicted_q.size() == 0) begin
					$display("%0t: unexpected status beat, expected none actual %h", $time, m_tdata);
					errors++;
				end else begin
					want = predicted_q.pop_front();
					check_field("send_request", 32'(want.send_request), 32'(m_tdata[0]));
					check_field("send_kind", 32'(want.send_kind), 32'(m_tdata[1]));
					check_field("send_sequence", 32'(want.send_sequence), 32'(m_tdata[17:2]));
					check_field("alive", 32'(want.alive), 32'(m_tdata[18]));
					check_field("lost_pulse", 32'(want.lost_pulse), 32'(m_tdata[19]));
					check_field("link_lamp", 32'(want.link_lamp), 32'(m_tdata[20]));
					check_field("activity_lamp", 32'(want.activity_lamp), 32'(m_tdata[21]));
					check_field("pad bits", 0, 32'(m_tdata[OUT_W-1:22]));
				end
			end
			outstanding <= predicted_q.size();
		end
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Top of the keepalive supervisor bench: clock, reset, register writes, input
// beats and output backpressure. Depends on lks_pkg, the rtl and keepalive_checker.
module testbench;
	import lks_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int ROUNDS         = 6;
	localparam int ROUND_ITEMS    = 155;

	// codes the block treats as other or unused
	localparam logic [1:0] ACT_RSVD    = 2'd3;
	localparam logic [1:0] KIND_PONG_RX = 2'd1;
	localparam logic [1:0] KIND_OTHER  = 2'd2;
	localparam logic [1:0] KIND_RSVD   = 2'd3;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data  = '0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata   = '0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	int mismatches;
	int outstanding;
	int idle_cycles = 0;
	int rx_beats    = 0;
	int rx_wait     = 0;
	bit rx_hold_done = 1'b0;
	bit sender_calm  = 1'b0;
	logic [TS_W-1:0] ts_now;

	always #5 clk = ~clk;

	link_keepalive_supervisor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	keepalive_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// mostly short gaps, now and then a long one
	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [TS_W-1:0] advance(input logic [TS_W-1:0] t);
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return t + $urandom_range(0, 300);
		if (r < 80) return t + $urandom_range(0, 3000);
		if (r < 92) return t + $urandom_range(0, 70000);
		if (r < 96) return $urandom;
		return t - $urandom_range(1, 200);
	endfunction

	task automatic send_item(input logic [1:0] action, input logic [TS_W-1:0] ts,
			input logic [1:0] kind, input logic [SEQ_W-1:0] fseq);
		int gap;
		gap = sender_calm ? 0 : rand_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'd0, fseq, kind, ts, action};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// stop offering beats and wait for every predicted status to drain
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(input logic [CFG_W-1:0] period, input logic [CFG_W-1:0] timeout,
			input logic [CFG_W-1:0] tx_hold, input logic [CFG_W-1:0] rx_hold);
		cfg_we    <= 1'b1;
		cfg_index <= REG_PING_PERIOD;
		cfg_data  <= period;
		@(posedge clk);
		cfg_index <= REG_LINK_TIMEOUT;
		cfg_data  <= timeout;
		@(posedge clk);
		cfg_index <= REG_TX_PULSE;
		cfg_data  <= tx_hold;
		@(posedge clk);
		cfg_index <= REG_RX_PULSE;
		cfg_data  <= rx_hold;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CFG_W-1:0] rand_span(input int lo);
		return CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(lo, 65535)
			: $urandom_range(lo, 2000));
	endfunction

	task automatic random_round(input int round);
		int r;
		logic [1:0] action;
		logic [1:0] kind;
		ts_now = (round == 1) ? 32'hFFFF_F000 : $urandom;
		for (int i = 0; i < ROUND_ITEMS; i++) begin
			sender_calm = (i >= 60 && i < 90);
			if (round == 3 && i == 80)
				drain();
			ts_now = advance(ts_now);
			r = $urandom_range(0, 99);
			if (r < 45) action = ACT_TICK;
			else if (r < 73) action = ACT_BYTE;
			else if (r < 98) action = ACT_FRAME;
			else action = ACT_RSVD;
			r = $urandom_range(0, 99);
			if (r < 40) kind = KIND_PING;
			else if (r < 70) kind = KIND_PONG_RX;
			else if (r < 97) kind = KIND_OTHER;
			else kind = KIND_RSVD;
			send_item(action, ts_now, kind, SEQ_W'($urandom));
		end
		sender_calm = 1'b0;
	endtask

	// receiver: random stalls, one long hold-off, one stretch always ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				rx_beats++;
			if (!rx_hold_done && rx_beats >= 400) begin
				rx_hold_done = 1'b1;
				rx_wait = 300;
			end
			if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else if (rx_beats >= 650 && rx_beats < 720) begin
				m_tready <= 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				rx_wait = rand_gap();
				m_tready <= (rx_wait == 0);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: period 500, timeout 1500, holds 60 / 250
		send_item(ACT_TICK, 32'd0, KIND_PING, 16'd0);
		send_item(ACT_TICK, 32'd500, KIND_PING, 16'd0);
		send_item(ACT_BYTE, 32'd510, KIND_PING, 16'hFFFF);
		send_item(ACT_FRAME, 32'd520, KIND_PING, 16'hFFFF);
		send_item(ACT_FRAME, 32'd530, KIND_PONG_RX, 16'h1234);
		send_item(ACT_FRAME, 32'd540, KIND_OTHER, 16'hAAAA);
		send_item(ACT_FRAME, 32'd550, KIND_RSVD, 16'h5555);
		send_item(ACT_RSVD, 32'd560, KIND_PING, 16'hFFFF);
		send_item(ACT_TICK, 32'd2100, KIND_PING, 16'd0);
		send_item(ACT_TICK, 32'd2100, KIND_PING, 16'd0);
		send_item(ACT_TICK, 32'hFFFF_FFFF, KIND_RSVD, 16'hFFFF);
		send_item(ACT_FRAME, 32'hFFFF_FFFF, KIND_PING, 16'd0);
		// wrap: exactly one period after the ping at all-ones
		send_item(ACT_TICK, 32'h0000_01F3, KIND_PING, 16'd0);
		send_item(ACT_BYTE, 32'h7FFF_FFFF, KIND_PING, 16'd0);
		send_item(ACT_TICK, 32'h8000_0000, KIND_PING, 16'd0);
		// time running backwards looks like a huge interval
		send_item(ACT_TICK, 32'h7FFF_FFF6, KIND_PING, 16'd0);
		drain();

		// shortest period and timeout, zero holds never light the lamp
		write_regs(16'd1, 16'd1, 16'd0, 16'd0);
		send_item(ACT_BYTE, 32'd1000, KIND_PING, 16'd0);
		send_item(ACT_FRAME, 32'd1000, KIND_PING, 16'h00FF);
		send_item(ACT_TICK, 32'd1001, KIND_PING, 16'd0);
		send_item(ACT_TICK, 32'd1001, KIND_PING, 16'd0);
		drain();

		// zero period and timeout: every tick pings, and a tick drops a live link
		write_regs(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
		send_item(ACT_FRAME, 32'd4000, KIND_OTHER, 16'd0);
		send_item(ACT_TICK, 32'd4000, KIND_PING, 16'd0);
		send_item(ACT_BYTE, 32'd4000, KIND_PING, 16'd0);
		send_item(ACT_TICK, 32'd4000, KIND_PING, 16'd0);
		drain();

		for (int round = 0; round < ROUNDS; round++) begin
			case (round)
				0: write_regs(PING_PERIOD_RST, LINK_TIMEOUT_RST, TX_PULSE_RST, RX_PULSE_RST);
				1: write_regs(16'd1, 16'd1, 16'd0, 16'd0);
				2: write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				default: write_regs(rand_span(1), rand_span(1), rand_span(0), rand_span(0));
			endcase
			random_round(round);
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

/* sim.f */
rtl/lks_pkg.sv
rtl/lks_state.sv
rtl/lks_beat.sv
rtl/link_keepalive_supervisor.sv
rtl/lks_checker.sv
tb/keepalive_checker.sv
tb/testbench.sv
